// ----- rtl/symmetry_axis_search_macros.svh -----
// Assertion macros for the symmetry axis search checker.
`ifndef SYMMETRY_AXIS_SEARCH_MACROS_SVH
`define SYMMETRY_AXIS_SEARCH_MACROS_SVH
// Implication checked every cycle outside reset.
`define SAS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symmetry_axis_search: label failed");
// Next-cycle implication checked outside reset.
`define SAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symmetry_axis_search: label failed");
`endif

// ----- rtl/sas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry axis search package
// Sizes, configuration indexes and shared types.
// ----------------------------------------------------------------------------
package sas_pkg;
  localparam int MaxBoxWidth  = 256;
  localparam int MaxBoxHeight = 128;
  localparam int StoreSize    = MaxBoxWidth * MaxBoxHeight;
  localparam int AddrW        = $clog2(StoreSize);
  localparam int ColW         = $clog2(MaxBoxWidth);
  localparam int RowW         = $clog2(MaxBoxHeight);
  localparam int WidthW       = ColW + 1;
  localparam int HeightW      = RowW + 1;
  localparam int ScoreW       = 24;
  localparam logic [ScoreW-1:0] ScoreMax = '1;
  localparam int QDepth       = 4;

  localparam logic [1:0] CfgXMin   = 2'd0;
  localparam logic [1:0] CfgWidth  = 2'd1;
  localparam logic [1:0] CfgHeight = 2'd2;
  localparam logic [1:0] CfgReach  = 2'd3;

  // Front-to-back queue entry: a store write, and on the last one a start mark.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [7:0]       pixel;
    logic             last;
  } load_word_t;

  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [WidthW-1:0]  dmax;
    logic [11:0]        x_min;
  } box_cfg_t;

  typedef enum logic [2:0] {
    S_LOAD, S_COL, S_READ, S_ACC, S_ROW, S_DONE, S_OUT
  } search_state_t;
endpackage

// ----- rtl/symmetry_axis_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry axis search
// Channel  Dir  Content
// s_axis   in   tdata[7:0] pixel
// m_axis   out  tdata[11:0] axis_x, tdata[35:12] best_score
// cfg      in   write enable, index, data
// Loading accepts one pixel per cycle through a four-word queue while it has room.
// Search reads each mirrored pair from the two read ports of the store in
// S_READ and adds its absolute difference in S_ACC, row by row per column.
// Input stalls once the queue fills during the search or the output wait.
// Reset is synchronous; the store is not cleared.
// ----------------------------------------------------------------------------
module symmetry_axis_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // axis_x, best_score
);
  import sas_pkg::*;

  load_word_t q_word;
  logic q_valid, q_ready;
  box_cfg_t box_cfg;

  sas_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .s_tvalid, .s_tready, .s_tdata,
    .q_word, .q_valid, .q_ready, .box_cfg
  );

  sas_back u_back (
    .clk, .rst, .q_word, .q_valid, .q_ready, .box_cfg, .m_tvalid, .m_tready, .m_tdata
  );
endmodule

// ----- rtl/sas_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry axis search front end
// Holds configuration, counts box pixels and queues store writes.
// ----------------------------------------------------------------------------
module sas_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  output sas_pkg::load_word_t   q_word,
  output logic                  q_valid,
  input  logic                  q_ready,
  output sas_pkg::box_cfg_t     box_cfg
);
  import sas_pkg::*;

  logic [11:0] x_min;
  logic [8:0]  width_reg;
  logic [7:0]  height_reg;
  logic [9:0]  reach_reg;
  logic [AddrW:0] load_count;
  logic [AddrW:0] total;
  logic [WidthW-1:0] w_eff;
  logic [HeightW-1:0] h_eff;
  logic [9:0] dm;
  load_word_t q_mem [QDepth];
  logic [$clog2(QDepth)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QDepth):0] fill;
  logic push, pop;

  always_comb begin
    w_eff = (width_reg == '0) ? WidthW'(1) :
            (width_reg > 9'(MaxBoxWidth)) ? WidthW'(MaxBoxWidth) : WidthW'(width_reg);
    h_eff = (height_reg == '0) ? HeightW'(1) :
            (height_reg > 8'(MaxBoxHeight)) ? HeightW'(MaxBoxHeight) : HeightW'(height_reg);
    dm = (reach_reg == '0) ? 10'd0 : reach_reg - 10'd1;
    box_cfg.width  = w_eff;
    box_cfg.height = h_eff;
    box_cfg.dmax   = (dm > 10'(w_eff)) ? w_eff : WidthW'(dm);
    box_cfg.x_min  = x_min;
    total = (AddrW+1)'(w_eff) * (AddrW+1)'(h_eff);
  end

  assign s_tready = (fill != ($clog2(QDepth)+1)'(QDepth));
  assign push = s_tvalid && s_tready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (fill != '0);
  assign q_word  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0; width_reg <= 9'd256; height_reg <= 8'd128; reach_reg <= 10'd256;
      load_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgXMin:   x_min      <= cfg_data;
        CfgWidth:  width_reg  <= cfg_data[8:0];
        CfgHeight: height_reg <= cfg_data[7:0];
        CfgReach:  reach_reg  <= cfg_data[9:0];
        default:   ;
      endcase
      load_count <= '0;
    end else if (push) begin
      load_count <= (load_count + 1'b1 >= total) ? '0 : load_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].addr  <= load_count[AddrW-1:0];
      q_mem[wr_ptr].pixel <= s_tdata;
      q_mem[wr_ptr].last  <= (load_count + 1'b1 >= total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end
endmodule

// ----- rtl/sas_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry axis search back end
// Writes the pixel store, then scores each column one mirrored pair at a time.
// ----------------------------------------------------------------------------
module sas_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sas_pkg::load_word_t   q_word,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  sas_pkg::box_cfg_t     box_cfg,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata
);
  import sas_pkg::*;

  search_state_t state, state_next;
  logic [7:0] store [StoreSize];
  logic [7:0] rd_a, rd_b;
  logic [AddrW-1:0] addr_a, addr_b;
  logic in_a, in_b, in_a_q, in_b_q;
  logic [WidthW-1:0] col, mir_dist;
  logic [HeightW-1:0] row;
  logic [AddrW-1:0] base;
  logic [ScoreW:0] sum;
  logic [ScoreW-1:0] best_value;
  logic [ColW-1:0] best_column;
  logic [7:0] pa, pb, diff;
  logic [11:0] axis_x;
  logic [ScoreW-1:0] score_out;
  logic [ScoreW:0] sum_add;

  assign q_ready = (state == S_LOAD);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {4'd0, score_out, axis_x};

  always_comb begin
    in_a   = (mir_dist <= col);
    in_b   = ((col + mir_dist) < box_cfg.width);
    addr_a = base + AddrW'(col - mir_dist);
    addr_b = base + AddrW'(col + mir_dist);
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && q_valid) store[q_word.addr] <= q_word.pixel;
    rd_a <= store[addr_a];
    rd_b <= store[addr_b];
    in_a_q <= in_a;
    in_b_q <= in_b;
  end

  always_comb begin
    pa = in_a_q ? rd_a : 8'd0;
    pb = in_b_q ? rd_b : 8'd0;
    diff = (pa > pb) ? pa - pb : pb - pa;
    sum_add = sum + (ScoreW+1)'(diff);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (q_valid && q_word.last) state_next = S_COL;
      S_COL:  state_next = (box_cfg.dmax == '0) ? S_ROW : S_READ;
      S_READ: state_next = S_ACC;
      S_ACC:  state_next = (mir_dist == box_cfg.dmax) ? S_ROW : S_READ;
      S_ROW:  if (sum >= (ScoreW+1)'(ScoreMax) ||
                  row + 1'b1 == box_cfg.height) state_next = S_DONE;
              else state_next = (box_cfg.dmax == '0) ? S_ROW : S_READ;
      S_DONE: state_next = (col + 1'b1 == box_cfg.width) ? S_OUT : S_COL;
      S_OUT:  if (m_tready) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        col <= '0;
      end
      S_COL: begin
        row <= '0; base <= '0; mir_dist <= WidthW'(1); sum <= '0;
      end
      S_ACC: begin
        sum <= sum_add;
        mir_dist <= mir_dist + 1'b1;
      end
      S_ROW: begin
        row <= row + 1'b1;
        base <= base + AddrW'(box_cfg.width);
        mir_dist <= WidthW'(1);
      end
      S_DONE: begin
        if (col == '0 || ScoreW'(sum >= (ScoreW+1)'(ScoreMax) ? ScoreMax : sum[ScoreW-1:0])
            < best_value) begin
          best_value  <= (sum >= (ScoreW+1)'(ScoreMax)) ? ScoreMax : sum[ScoreW-1:0];
          best_column <= col[ColW-1:0];
        end
        col <= col + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    axis_x = box_cfg.x_min + 12'(best_column);
    score_out = best_value;
  end
endmodule

// ----- rtl/sas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry axis search checker
// Port-level checks over time.
// ----------------------------------------------------------------------------
`include "symmetry_axis_search_macros.svh"
module sas_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `SAS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SAS_ASSERT(a_pad, m_tvalid, m_tdata[39:36] == 4'd0)
  `SAS_ASSERT(a_rst, $fell(rst), s_tready && !m_tvalid)
endmodule

bind symmetry_axis_search sas_checker u_checker (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
